/* design/assert_macros.svh */
// Assertion macros used by the result stream checker of the decoder.
// Depends on nothing; take it in by `include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error("assertion failed");

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error("assertion failed");

`endif

/* design/rcfd_pkg.sv */
// Types and constants of the remote control frame decoder.
// Used by the front, queue, back and top modules; depends on nothing.
package rcfd_pkg;

	localparam int FRAME_BYTES = 18;
	localparam int FRAME_BITS  = 8 * FRAME_BYTES;
	localparam int CH_W        = 11;
	localparam int SW_W        = 2;
	localparam int VAL_W       = 16;
	localparam int ID_W        = 4;
	localparam int QUEUE_DEPTH = 2;

	// Input item kinds
	typedef enum logic [1:0] {
		OP_BYTE     = 2'd0,
		OP_IDLE     = 2'd1,
		OP_FAILSAFE = 2'd2
	} op_t;

	// Commands passed from front to back
	typedef enum logic {
		CMD_UNPACK   = 1'b0,
		CMD_FAILSAFE = 1'b1
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t              kind;
		logic [FRAME_BITS-1:0]  frame;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef struct packed {
		logic [CH_W-1:0] low;
		logic [CH_W-1:0] high;
		logic [CH_W-1:0] center;
	} cfg_t;

	// Configuration register indexes
	localparam logic [1:0] REG_LOW    = 2'd0;
	localparam logic [1:0] REG_HIGH   = 2'd1;
	localparam logic [1:0] REG_CENTER = 2'd2;

	localparam logic [CH_W-1:0] LOW_RESET    = 11'd364;
	localparam logic [CH_W-1:0] HIGH_RESET   = 11'd1684;
	localparam logic [CH_W-1:0] CENTER_RESET = 11'd1024;

	// Field ids of one result run
	localparam logic [ID_W-1:0] FIELD_CH0     = 4'd0;
	localparam logic [ID_W-1:0] FIELD_CH1     = 4'd1;
	localparam logic [ID_W-1:0] FIELD_CH2     = 4'd2;
	localparam logic [ID_W-1:0] FIELD_CH3     = 4'd3;
	localparam logic [ID_W-1:0] FIELD_S1      = 4'd4;
	localparam logic [ID_W-1:0] FIELD_S2      = 4'd5;
	localparam logic [ID_W-1:0] FIELD_MOUSE_X = 4'd6;
	localparam logic [ID_W-1:0] FIELD_MOUSE_Y = 4'd7;
	localparam logic [ID_W-1:0] FIELD_MOUSE_Z = 4'd8;
	localparam logic [ID_W-1:0] FIELD_PRESS_L = 4'd9;
	localparam logic [ID_W-1:0] FIELD_PRESS_R = 4'd10;
	localparam logic [ID_W-1:0] FIELD_KEYS    = 4'd11;
	localparam logic [ID_W-1:0] FIELD_ROTOR   = 4'd12;
	localparam logic [ID_W-1:0] FIELD_PREV_CH1 = 4'd13;
	localparam logic [ID_W-1:0] FIELD_PREV_S2 = 4'd14;
	localparam logic [ID_W-1:0] FIELD_LAST    = FIELD_PREV_S2;

endpackage

/* design/rcfd_queue.sv */
// Two-entry command queue between the decoder front and back.
// Depends on rcfd_pkg for the command and status types.
module rcfd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  rcfd_pkg::cmd_t     push_cmd,
	input  logic               pop,
	output rcfd_pkg::cmd_t     head_cmd,
	output rcfd_pkg::q_status_t status
);

	localparam int PTR_W = $clog2(rcfd_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(rcfd_pkg::QUEUE_DEPTH + 1);

	rcfd_pkg::cmd_t    entry_q [rcfd_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign status.full  = (count_q == CNT_W'(rcfd_pkg::QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign head_cmd     = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(rcfd_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(rcfd_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* design/rcfd_front.sv */
// Decoder front: accepts input items, counts and stores frame bytes,
// and queues unpack and failsafe commands. Depends on rcfd_pkg.
module rcfd_front #(
	parameter int BUFFER_BYTES = 36
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          in_op,
	input  logic [7:0]          in_byte,
	input  rcfd_pkg::q_status_t q_status,
	output logic                push,
	output rcfd_pkg::cmd_t      push_cmd
);

	localparam int CW     = $clog2(BUFFER_BYTES + 1);
	localparam int FIDX_W = $clog2(rcfd_pkg::FRAME_BYTES);

	logic [7:0]    frame_q [rcfd_pkg::FRAME_BYTES];
	logic [CW-1:0] count_q;
	logic          accept;
	rcfd_pkg::op_t op;

	assign in_ready = !q_status.full;
	assign accept   = in_valid && in_ready;
	assign op       = rcfd_pkg::op_t'(in_op);

	always_comb begin
		for (int i = 0; i < rcfd_pkg::FRAME_BYTES; i++) begin
			push_cmd.frame[8*i +: 8] = frame_q[i];
		end
		push_cmd.kind = rcfd_pkg::CMD_UNPACK;
		push          = 1'b0;
		case (op)
			rcfd_pkg::OP_IDLE: begin
				push = accept && (count_q == CW'(rcfd_pkg::FRAME_BYTES));
			end
			rcfd_pkg::OP_FAILSAFE: begin
				push_cmd.kind = rcfd_pkg::CMD_FAILSAFE;
				push          = accept;
			end
			default: push = 1'b0;
		endcase
	end

	// Bytes beyond the frame are counted but not kept
	always_ff @(posedge clk) begin
		if (accept && (op == rcfd_pkg::OP_BYTE) &&
				(count_q < CW'(rcfd_pkg::FRAME_BYTES))) begin
			frame_q[count_q[FIDX_W-1:0]] <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			case (op)
				rcfd_pkg::OP_BYTE: begin
					if (count_q < CW'(BUFFER_BYTES)) begin
						count_q <= count_q + CW'(1);
					end
				end
				rcfd_pkg::OP_IDLE: count_q <= '0;
				default:           count_q <= count_q;
			endcase
		end
	end

endmodule

/* design/rcfd_back.sv */
// Decoder back: unpacks frames, applies failsafe repair and streams the
// fifteen fields of each run. Depends on rcfd_pkg.
module rcfd_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rcfd_pkg::cfg_t              cfg,
	input  rcfd_pkg::cmd_t              head_cmd,
	input  rcfd_pkg::q_status_t         q_status,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [rcfd_pkg::ID_W-1:0]   out_id,
	output logic [rcfd_pkg::VAL_W-1:0]  out_value,
	output logic                        out_last
);

	logic [rcfd_pkg::CH_W-1:0]  stick_q [4];
	logic [rcfd_pkg::SW_W-1:0]  switch_q [2];
	logic [rcfd_pkg::VAL_W-1:0] mouse_q [6];
	logic [rcfd_pkg::VAL_W-1:0] rotor_q;
	logic [rcfd_pkg::CH_W-1:0]  prev_ch1_q;
	logic [rcfd_pkg::SW_W-1:0]  prev_s2_q;
	logic                       active_q;
	logic [rcfd_pkg::ID_W-1:0]  idx_q;

	logic [rcfd_pkg::CH_W-1:0]  fs_stick [4];
	logic [rcfd_pkg::SW_W-1:0]  fs_switch [2];
	logic [rcfd_pkg::VAL_W-1:0] fs_rotor;
	logic [rcfd_pkg::FRAME_BITS-1:0] fb;
	logic                       run_done;

	assign fb       = head_cmd.frame;
	assign run_done = active_q && out_ready && (idx_q == rcfd_pkg::FIELD_LAST);
	assign pop      = !q_status.empty && (!active_q || run_done);

	// Failsafe repair; a negative rotor always falls below the low limit
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			fs_stick[k] = ((stick_q[k] < cfg.low) || (stick_q[k] > cfg.high)) ?
				cfg.center : stick_q[k];
		end
		fs_rotor = (rotor_q[15] ||
				(rotor_q < {5'd0, cfg.low}) || (rotor_q > {5'd0, cfg.high})) ?
			{5'd0, cfg.center} : rotor_q;
		for (int k = 0; k < 2; k++) begin
			fs_switch[k] = (switch_q[k] == 2'd0) ? 2'd1 : switch_q[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 4; k++) stick_q[k] <= '0;
			for (int k = 0; k < 2; k++) switch_q[k] <= '0;
			for (int k = 0; k < 6; k++) mouse_q[k] <= '0;
			rotor_q    <= '0;
			prev_ch1_q <= '0;
			prev_s2_q  <= '0;
			active_q   <= 1'b0;
			idx_q      <= '0;
		end else if (pop) begin
			case (head_cmd.kind)
				rcfd_pkg::CMD_UNPACK: begin
					prev_ch1_q  <= stick_q[1];
					prev_s2_q   <= switch_q[1];
					stick_q[0]  <= fb[10:0];
					stick_q[1]  <= fb[21:11];
					stick_q[2]  <= fb[32:22];
					stick_q[3]  <= fb[43:33];
					switch_q[1] <= fb[45:44];
					switch_q[0] <= fb[47:46];
					mouse_q[0]  <= fb[63:48];
					mouse_q[1]  <= fb[79:64];
					mouse_q[2]  <= fb[95:80];
					mouse_q[3]  <= {8'd0, fb[103:96]};
					mouse_q[4]  <= {8'd0, fb[111:104]};
					mouse_q[5]  <= fb[127:112];
					rotor_q     <= fb[143:128];
				end
				default: begin
					for (int k = 0; k < 4; k++) stick_q[k] <= fs_stick[k];
					for (int k = 0; k < 2; k++) switch_q[k] <= fs_switch[k];
					rotor_q <= fs_rotor;
				end
			endcase
			active_q <= 1'b1;
			idx_q    <= '0;
		end else if (active_q && out_ready) begin
			if (idx_q == rcfd_pkg::FIELD_LAST) begin
				active_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 4'd1;
			end
		end
	end

	assign out_valid = active_q;
	assign out_id    = idx_q;
	assign out_last  = (idx_q == rcfd_pkg::FIELD_LAST);

	always_comb begin
		case (idx_q)
			rcfd_pkg::FIELD_CH0:      out_value = {5'd0, stick_q[0]};
			rcfd_pkg::FIELD_CH1:      out_value = {5'd0, stick_q[1]};
			rcfd_pkg::FIELD_CH2:      out_value = {5'd0, stick_q[2]};
			rcfd_pkg::FIELD_CH3:      out_value = {5'd0, stick_q[3]};
			rcfd_pkg::FIELD_S1:       out_value = {14'd0, switch_q[0]};
			rcfd_pkg::FIELD_S2:       out_value = {14'd0, switch_q[1]};
			rcfd_pkg::FIELD_MOUSE_X:  out_value = mouse_q[0];
			rcfd_pkg::FIELD_MOUSE_Y:  out_value = mouse_q[1];
			rcfd_pkg::FIELD_MOUSE_Z:  out_value = mouse_q[2];
			rcfd_pkg::FIELD_PRESS_L:  out_value = mouse_q[3];
			rcfd_pkg::FIELD_PRESS_R:  out_value = mouse_q[4];
			rcfd_pkg::FIELD_KEYS:     out_value = mouse_q[5];
			rcfd_pkg::FIELD_ROTOR:    out_value = rotor_q;
			rcfd_pkg::FIELD_PREV_CH1: out_value = {5'd0, prev_ch1_q};
			rcfd_pkg::FIELD_PREV_S2:  out_value = {14'd0, prev_s2_q};
			default:                  out_value = '0;
		endcase
	end

endmodule

/* design/remote_control_frame_decoder_core.sv */
// Top level of the remote control frame decoder: configuration registers,
// front, command queue and back. Depends on rcfd_pkg and the three submodules.
//
// Use: feed UART events on the s_ stream. s_tuser[1:0] gives the kind
// (0 received byte in s_tdata[7:0], 1 idle line, 2 failsafe check).
// One request is accepted per cycle while the command queue has room.
// An idle line after exactly 18 bytes, or any failsafe check, starts a run
// of 15 results on the m_ stream: m_tuser is the field id, m_tdata the
// 16-bit field value, m_tlast marks field 14.
// With the back idle, an accepted request that starts a run is written into
// the command queue, then popped by the back, which loads its field registers
// and shows the first result; a run then moves one result per cycle while the
// receiver keeps m_tready high. The back starts the next queued run in the
// cycle after the last field of the previous one is taken.
// When the receiver stalls, the current result holds; up to two commands
// wait in the queue, after which s_tready falls until a run finishes.
// Byte and other idle requests never use the queue but still wait on it.
// Reset clears the byte count, the decoded fields and the queue, and loads
// the limits 364 / 1684 and the center 1024. The APB port writes the
// limit and center registers at 0x0, 0x4 and 0x8; pready is always high.
module remote_control_frame_decoder_core #(
	parameter int BUFFER_BYTES = 36
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic [1:0]  s_tuser,   // [1:0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] field_value
	output logic [3:0]  m_tuser,   // [3:0] field_id
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	rcfd_pkg::cfg_t      cfg_q;
	rcfd_pkg::q_status_t q_status;
	rcfd_pkg::cmd_t      push_cmd;
	rcfd_pkg::cmd_t      head_cmd;
	logic                push;
	logic                pop;
	logic                cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low    <= rcfd_pkg::LOW_RESET;
			cfg_q.high   <= rcfd_pkg::HIGH_RESET;
			cfg_q.center <= rcfd_pkg::CENTER_RESET;
		end else if (cfg_write) begin
			case (paddr[3:2])
				rcfd_pkg::REG_LOW:    cfg_q.low    <= pwdata[10:0];
				rcfd_pkg::REG_HIGH:   cfg_q.high   <= pwdata[10:0];
				rcfd_pkg::REG_CENTER: cfg_q.center <= pwdata[10:0];
				default:              cfg_q        <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			rcfd_pkg::REG_LOW:    prdata = {21'd0, cfg_q.low};
			rcfd_pkg::REG_HIGH:   prdata = {21'd0, cfg_q.high};
			rcfd_pkg::REG_CENTER: prdata = {21'd0, cfg_q.center};
			default:              prdata = '0;
		endcase
	end

	rcfd_front #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_op    (s_tuser),
		.in_byte  (s_tdata),
		.q_status (q_status),
		.push     (push),
		.push_cmd (push_cmd)
	);

	rcfd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.status   (q_status)
	);

	rcfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head_cmd  (head_cmd),
		.q_status  (q_status),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_id    (m_tuser),
		.out_value (m_tdata),
		.out_last  (m_tlast)
	);

endmodule

/* design/rcfd_checker.sv */
// Port-level checks of the decoder result stream, bound to the top level.
// Depends on assert_macros.svh and rcfd_pkg for the field ids.
`include "assert_macros.svh"

module rcfd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [3:0]  m_tuser,
	input logic        m_tlast
);

	// Last marks the final field and nothing else
	`ASSERT_SAME(a_last_id, clk, arst_n, m_tvalid, (m_tlast == (m_tuser == rcfd_pkg::FIELD_LAST)))

	// Fields of a run follow without gaps and in order
	`ASSERT_NEXT(a_run_order, clk, arst_n, (m_tvalid && m_tready && !m_tlast), (m_tvalid && (m_tuser == $past(m_tuser) + 4'd1)))

	// A new run starts at the first field
	`ASSERT_NEXT(a_run_start, clk, arst_n, (m_tvalid && m_tready && m_tlast), (!m_tvalid || (m_tuser == rcfd_pkg::FIELD_CH0)))

	// Hold a stalled result
	`ASSERT_NEXT(a_stall_hold, clk, arst_n, (m_tvalid && !m_tready), (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))

endmodule

bind remote_control_frame_decoder_core rcfd_checker u_rcfd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

/* tb/rcfd_field_checker.sv */
`timescale 1ns / 100ps
// Result checker for the remote control frame decoder: watches the request,
// result and register channels, predicts every field run and compares it.
// Depends on rcfd_pkg.
module rcfd_field_checker #(
	parameter int BUFFER_BYTES = 36
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic [1:0]  s_tuser,   // [1:0] op
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,   // [15:0] field_value
	input  logic [3:0]  m_tuser,   // [3:0] field_id
	input  logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          mismatch_count,
	output int          fields_pending
);

	localparam int FIELD_COUNT = int'(rcfd_pkg::FIELD_LAST) + 1;
	localparam int FIDX_W      = $clog2(rcfd_pkg::FRAME_BYTES);

	typedef struct packed {
		logic [rcfd_pkg::ID_W-1:0]  id;
		logic [rcfd_pkg::VAL_W-1:0] value;
		logic                       is_last;
	} field_result_t;

	field_result_t              expected_fields [$];
	rcfd_pkg::cfg_t             limits;
	logic [7:0]                 rx_bytes [rcfd_pkg::FRAME_BYTES];
	logic [5:0]                 rx_count;
	logic [rcfd_pkg::CH_W-1:0]  sticks [4];
	logic [rcfd_pkg::SW_W-1:0]  switches [2];
	logic [rcfd_pkg::VAL_W-1:0] mouse_keys [6];   // x, y, z, press_l, press_r, keys
	logic [rcfd_pkg::VAL_W-1:0] rotor;
	logic [rcfd_pkg::CH_W-1:0]  prev_ch1;
	logic [rcfd_pkg::SW_W-1:0]  prev_s2;

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("[%0t] field check: %s", $time, msg);
	endtask

	function automatic void clear_decoder();
		limits.low    = rcfd_pkg::LOW_RESET;
		limits.high   = rcfd_pkg::HIGH_RESET;
		limits.center = rcfd_pkg::CENTER_RESET;
		rx_count = '0;
		rotor    = '0;
		prev_ch1 = '0;
		prev_s2  = '0;
		for (int i = 0; i < rcfd_pkg::FRAME_BYTES; i++)
			rx_bytes[i] = '0;
		for (int k = 0; k < 4; k++)
			sticks[k] = '0;
		for (int k = 0; k < 2; k++)
			switches[k] = '0;
		for (int k = 0; k < 6; k++)
			mouse_keys[k] = '0;
		expected_fields.delete();
	endfunction

	function automatic void unpack_frame();
		logic [rcfd_pkg::FRAME_BITS-1:0] f;
		for (int i = 0; i < rcfd_pkg::FRAME_BYTES; i++)
			f[8*i +: 8] = rx_bytes[i];
		prev_ch1 = sticks[1];
		prev_s2  = switches[1];
		sticks[0]   = f[10:0];
		sticks[1]   = f[21:11];
		sticks[2]   = f[32:22];
		sticks[3]   = f[43:33];
		switches[1] = f[45:44];
		switches[0] = f[47:46];
		for (int k = 0; k < 3; k++)
			mouse_keys[k] = f[48 + 16*k +: 16];
		mouse_keys[3] = {8'h00, f[103:96]};
		mouse_keys[4] = {8'h00, f[111:104]};
		mouse_keys[5] = f[127:112];
		rotor         = f[143:128];
	endfunction

	function automatic void repair_out_of_range();
		int signed_rotor;
		for (int k = 0; k < 4; k++) begin
			if (sticks[k] < limits.low || sticks[k] > limits.high)
				sticks[k] = limits.center;
		end
		// rotor is a signed word, so any negative value falls below the low limit
		signed_rotor = int'($signed(rotor));
		if (signed_rotor < int'(limits.low) || signed_rotor > int'(limits.high))
			rotor = {5'd0, limits.center};
		for (int k = 0; k < 2; k++) begin
			if (switches[k] == 2'd0)
				switches[k] = 2'd1;
		end
	endfunction

	function automatic void queue_field_run();
		logic [rcfd_pkg::VAL_W-1:0] vals [FIELD_COUNT];
		field_result_t              r;
		vals[rcfd_pkg::FIELD_CH0]      = {5'd0, sticks[0]};
		vals[rcfd_pkg::FIELD_CH1]      = {5'd0, sticks[1]};
		vals[rcfd_pkg::FIELD_CH2]      = {5'd0, sticks[2]};
		vals[rcfd_pkg::FIELD_CH3]      = {5'd0, sticks[3]};
		vals[rcfd_pkg::FIELD_S1]       = {14'd0, switches[0]};
		vals[rcfd_pkg::FIELD_S2]       = {14'd0, switches[1]};
		vals[rcfd_pkg::FIELD_MOUSE_X]  = mouse_keys[0];
		vals[rcfd_pkg::FIELD_MOUSE_Y]  = mouse_keys[1];
		vals[rcfd_pkg::FIELD_MOUSE_Z]  = mouse_keys[2];
		vals[rcfd_pkg::FIELD_PRESS_L]  = mouse_keys[3];
		vals[rcfd_pkg::FIELD_PRESS_R]  = mouse_keys[4];
		vals[rcfd_pkg::FIELD_KEYS]     = mouse_keys[5];
		vals[rcfd_pkg::FIELD_ROTOR]    = rotor;
		vals[rcfd_pkg::FIELD_PREV_CH1] = {5'd0, prev_ch1};
		vals[rcfd_pkg::FIELD_PREV_S2]  = {14'd0, prev_s2};
		for (int k = 0; k < FIELD_COUNT; k++) begin
			r.id      = rcfd_pkg::ID_W'(k);
			r.value   = vals[k];
			r.is_last = (r.id == rcfd_pkg::FIELD_LAST);
			expected_fields.push_back(r);
		end
	endfunction

	function automatic void decode_request(input logic [1:0] op, input logic [7:0] data);
		logic whole;
		case (op)
			rcfd_pkg::OP_BYTE: begin
				// count past the frame, store only its bytes
				if (rx_count < rcfd_pkg::FRAME_BYTES)
					rx_bytes[rx_count[FIDX_W-1:0]] = data;
				if (rx_count < BUFFER_BYTES)
					rx_count++;
			end
			rcfd_pkg::OP_IDLE: begin
				whole = (rx_count == rcfd_pkg::FRAME_BYTES);
				rx_count = '0;
				if (whole) begin
					unpack_frame();
					queue_field_run();
				end
			end
			rcfd_pkg::OP_FAILSAFE: begin
				repair_out_of_range();
				queue_field_run();
			end
			default: ;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		field_result_t want;
		if (!arst_n) begin
			clear_decoder();
			mismatch_count = 0;
			fields_pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_fields.size() == 0) begin
					report_mismatch($sformatf("unexpected field id %0d value %04h",
						m_tuser, m_tdata));
				end else begin
					want = expected_fields.pop_front();
					if (m_tuser !== want.id)
						report_mismatch($sformatf("field id %0d, want %0d", m_tuser, want.id));
					if (m_tdata !== want.value)
						report_mismatch($sformatf("field %0d value %04h, want %04h",
							want.id, m_tdata, want.value));
					if (m_tlast !== want.is_last)
						report_mismatch($sformatf("field %0d tlast %0b, want %0b",
							want.id, m_tlast, want.is_last));
				end
			end
			if (s_tvalid && s_tready)
				decode_request(s_tuser, s_tdata);
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					rcfd_pkg::REG_LOW:    limits.low    = pwdata[rcfd_pkg::CH_W-1:0];
					rcfd_pkg::REG_HIGH:   limits.high   = pwdata[rcfd_pkg::CH_W-1:0];
					rcfd_pkg::REG_CENTER: limits.center = pwdata[rcfd_pkg::CH_W-1:0];
					default: ;
				endcase
			end
			fields_pending <= expected_fields.size();
		end
	end

endmodule

/* tb/remote_control_frame_decoder_core_tb.sv */
`timescale 1ns / 100ps
// Top of the frame decoder testbench: clock, reset, request and register
// stimulus, receiver back-pressure and the verdict.
// Depends on rcfd_pkg, remote_control_frame_decoder_core and rcfd_field_checker.
module remote_control_frame_decoder_core_tb;

	localparam int         BUFFER_BYTES = 36;
	localparam int         HOLD_CYCLES  = 60;
	localparam logic [1:0] OP_UNUSED    = 2'd3;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;
	logic [1:0]  s_tuser  = rcfd_pkg::OP_BYTE;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic [3:0]  m_tuser;
	logic        m_tlast;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [3:0]  paddr    = 4'h0;
	logic [31:0] pwdata   = 32'h0;
	logic [31:0] prdata;
	logic        pready;

	int mismatch_count;
	int fields_pending;
	int requests_sent    = 0;
	bit sender_gaps_on   = 1'b1;
	bit receiver_gaps_on = 1'b1;
	bit hold_off_req     = 1'b0;

	always #5 clk = ~clk;

	remote_control_frame_decoder_core #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready)
	);

	rcfd_field_checker #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.pready(pready),
		.mismatch_count(mismatch_count), .fields_pending(fields_pending)
	);

	// Offer one request and hold it until taken; valid stays up for the next one.
	task automatic send_request(input logic [1:0] op, input logic [7:0] data);
		if (sender_gaps_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= data;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (op != OP_UNUSED)
			requests_sent++;
	endtask

	function automatic logic [7:0] frame_byte();
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(0, 1) ? 8'hFF : 8'h00;
		return 8'($urandom);
	endfunction

	task automatic send_bytes(input int count);
		repeat (count) send_request(rcfd_pkg::OP_BYTE, frame_byte());
	endtask

	// Mostly whole frames with random content; the rest are short, long or stray requests.
	task automatic send_random_sequence();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick <= 5) begin
			send_bytes(rcfd_pkg::FRAME_BYTES);
			send_request(rcfd_pkg::OP_IDLE, 8'($urandom));
			if ($urandom_range(0, 2) == 0)
				send_request(rcfd_pkg::OP_FAILSAFE, 8'($urandom));
		end else if (pick == 6) begin
			send_bytes($urandom_range(1, rcfd_pkg::FRAME_BYTES - 1));
			send_request(rcfd_pkg::OP_IDLE, 8'($urandom));
		end else if (pick == 7) begin
			send_bytes($urandom_range(rcfd_pkg::FRAME_BYTES + 1, BUFFER_BYTES + 9));
			send_request(rcfd_pkg::OP_IDLE, 8'($urandom));
		end else if (pick == 8) begin
			send_request(rcfd_pkg::OP_FAILSAFE, 8'($urandom));
		end else begin
			send_request(2'($urandom_range(0, 3)), 8'($urandom));
		end
	endtask

	task automatic run_random_phase(input int budget);
		int start;
		start = requests_sent;
		while (requests_sent - start < budget)
			send_random_sequence();
	endtask

	// Drop valid and wait for every predicted field, then let the back settle.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (fields_pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] index,
			input logic [rcfd_pkg::CH_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {index, 2'b00};
		pwdata  <= {21'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_limits(input logic [rcfd_pkg::CH_W-1:0] low,
			input logic [rcfd_pkg::CH_W-1:0] high,
			input logic [rcfd_pkg::CH_W-1:0] center);
		write_reg(rcfd_pkg::REG_LOW, low);
		write_reg(rcfd_pkg::REG_HIGH, high);
		write_reg(rcfd_pkg::REG_CENTER, center);
	endtask

	// Receiver: random stalls, plus one long hold when asked
	initial begin
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else if (receiver_gaps_on && $urandom_range(0, 6) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: repair of the all-zero reset state, unused op, wrong length,
		// an all-ones frame and its repair.
		send_request(rcfd_pkg::OP_FAILSAFE, 8'h00);
		send_request(OP_UNUSED, 8'hFF);
		send_request(rcfd_pkg::OP_BYTE, 8'h5A);
		send_request(rcfd_pkg::OP_IDLE, 8'h00);
		repeat (rcfd_pkg::FRAME_BYTES) send_request(rcfd_pkg::OP_BYTE, 8'hFF);
		send_request(rcfd_pkg::OP_IDLE, 8'hFF);
		send_request(rcfd_pkg::OP_FAILSAFE, 8'h00);
		wait_drained();

		// Overflow the byte count
		repeat (BUFFER_BYTES + 2) send_request(rcfd_pkg::OP_BYTE, 8'h00);
		send_request(rcfd_pkg::OP_IDLE, 8'h00);
		wait_drained();

		// Widest window, center at zero
		write_limits(11'd0, 11'd2047, 11'd0);
		run_random_phase(6);
		wait_drained();

		// Inverted window; fill the block behind a long receiver hold
		write_limits(11'd2047, 11'd0, 11'd2047);
		hold_off_req = 1'b1;
		repeat (6) send_request(rcfd_pkg::OP_FAILSAFE, 8'($urandom));
		wait_drained();

		write_limits(11'($urandom_range(0, 1023)), 11'($urandom_range(1024, 2047)),
			11'($urandom_range(0, 2047)));
		run_random_phase(6);
		wait_drained();

		// Last part back at the reset limits, with no idling on either side
		write_limits(rcfd_pkg::LOW_RESET, rcfd_pkg::HIGH_RESET, rcfd_pkg::CENTER_RESET);
		sender_gaps_on   = 1'b0;
		receiver_gaps_on = 1'b0;
		run_random_phase(6);
		wait_drained();
		repeat (20) @(posedge clk);

		if (mismatch_count == 0 && fields_pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

endmodule

/* sim.f */
+incdir+design
design/rcfd_pkg.sv
design/rcfd_queue.sv
design/rcfd_front.sv
design/rcfd_back.sv
design/remote_control_frame_decoder_core.sv
design/rcfd_checker.sv
tb/rcfd_field_checker.sv
tb/remote_control_frame_decoder_core_tb.sv
